// ===== rtl/clc_pkg.sv =====
// Shared types and character codes for the C source line classifier.
package clc_pkg;

    // Character codes that steer the scanner
    localparam logic [7:0] CHAR_STAR      = 8'h2A;
    localparam logic [7:0] CHAR_SLASH     = 8'h2F;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_CR        = 8'h0D;

    // Line classes
    typedef enum logic [1:0] {
        LINE_BLANK   = 2'd0,
        LINE_CODE    = 2'd1,
        LINE_COMMENT = 2'd2,
        LINE_INLINE  = 2'd3
    } line_class_t;

    // Scanner state carried from item to item
    typedef struct packed {
        logic       in_block_comment;
        logic       in_literal;
        logic [7:0] held_char;
        logic       held_valid;
        logic       rest_ignored;
        logic       line_saw_code;
        logic       line_saw_comment;
    } scan_state_t;

    // Line-end report from the scanner to the counters
    typedef struct packed {
        logic done;
        logic saw_code;
        logic saw_comment;
    } line_flags_t;

endpackage

// ===== rtl/clc_char_unit.sv =====
// Per-character scanner: comment, string and lookahead tracking for one item.
module clc_char_unit (
    input  clc_pkg::scan_state_t state,
    input  logic [7:0]           char_code,
    input  logic                 end_of_line,
    input  logic                 fire,
    output clc_pkg::scan_state_t state_next,
    output clc_pkg::line_flags_t flags
);
    import clc_pkg::*;

    typedef struct packed {
        scan_state_t st;
        logic        skip;
    } handle_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    // Act on byte h with lookahead n when has_next is set
    function automatic handle_t handle_byte(input scan_state_t s, input logic [7:0] h,
                                            input logic has_next, input logic [7:0] n);
        handle_t r;
        r.st   = s;
        r.skip = 1'b0;
        if (!is_blank(h)) begin
            if (s.in_block_comment) begin
                r.st.line_saw_comment = 1'b1;
                if ((h == CHAR_STAR) && has_next && (n == CHAR_SLASH)) begin
                    r.skip               = 1'b1;
                    r.st.in_block_comment = 1'b0;
                end
            end else if (s.in_literal) begin
                if (h == CHAR_BACKSLASH) begin
                    r.skip = has_next;
                end else if (h == CHAR_QUOTE) begin
                    r.st.in_literal = 1'b0;
                end
                r.st.line_saw_code = 1'b1;
            end else if ((h == CHAR_SLASH) && has_next && (n == CHAR_STAR)) begin
                r.st.in_block_comment = 1'b1;
                r.st.line_saw_comment = 1'b1;
                r.skip                = 1'b1;
            end else if ((h == CHAR_SLASH) && has_next && (n == CHAR_SLASH)) begin
                r.st.line_saw_comment = 1'b1;
                r.st.rest_ignored     = 1'b1;
            end else begin
                if (h == CHAR_QUOTE) begin
                    r.st.in_literal = 1'b1;
                end
                r.st.line_saw_code = 1'b1;
            end
        end
        return r;
    endfunction

    handle_t     first_r;
    handle_t     last_r;
    scan_state_t mid;
    scan_state_t fin;

    // Resolve the held byte against the new one, then hold or drop the new one
    always_comb
    begin
        mid = state;
        first_r = handle_byte(state, state.held_char, 1'b1, char_code);
        if (!state.rest_ignored) begin
            if (state.held_valid) begin
                mid = first_r.st;
            end
            if (state.held_valid && first_r.skip) begin
                mid.held_valid = 1'b0;
            end else if (mid.rest_ignored) begin
                mid.held_valid = 1'b0;
            end else begin
                mid.held_char  = char_code;
                mid.held_valid = 1'b1;
            end
        end
    end

    // Flush the held byte at line end and clear the per-line state
    always_comb
    begin
        fin    = mid;
        last_r = handle_byte(mid, mid.held_char, 1'b0, 8'h00);
        if (mid.held_valid && !mid.rest_ignored) begin
            fin = last_r.st;
        end
        flags.done        = fire && end_of_line;
        flags.saw_code    = fin.line_saw_code;
        flags.saw_comment = fin.line_saw_comment;
        if (end_of_line) begin
            fin.held_char        = 8'h00;
            fin.held_valid       = 1'b0;
            fin.rest_ignored     = 1'b0;
            fin.line_saw_code    = 1'b0;
            fin.line_saw_comment = 1'b0;
            state_next           = fin;
        end else begin
            state_next = mid;
        end
    end

endmodule

// ===== rtl/clc_line_counters.sv =====
// Saturating line counters and line class decode.
module clc_line_counters #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  clc_pkg::line_flags_t     flags,
    output clc_pkg::line_class_t     line_class,
    output logic [COUNT_WIDTH-1:0]   total_next,
    output logic [COUNT_WIDTH-1:0]   blank_next,
    output logic [COUNT_WIDTH-1:0]   code_next,
    output logic [COUNT_WIDTH-1:0]   comment_next,
    output logic [COUNT_WIDTH-1:0]   inline_next
);
    import clc_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] total_reg;
    logic [COUNT_WIDTH-1:0] blank_reg;
    logic [COUNT_WIDTH-1:0] code_reg;
    logic [COUNT_WIDTH-1:0] comment_reg;
    logic [COUNT_WIDTH-1:0] inline_reg;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // Decode the class and bump the matching counters
    always_comb
    begin
        total_next   = total_reg;
        blank_next   = blank_reg;
        code_next    = code_reg;
        comment_next = comment_reg;
        inline_next  = inline_reg;
        if (flags.saw_code && flags.saw_comment) begin
            line_class = LINE_INLINE;
        end else if (flags.saw_code) begin
            line_class = LINE_CODE;
        end else if (flags.saw_comment) begin
            line_class = LINE_COMMENT;
        end else begin
            line_class = LINE_BLANK;
        end
        if (flags.done) begin
            total_next = sat_inc(total_reg);
            case (line_class)
                LINE_INLINE:
                begin
                    code_next   = sat_inc(code_reg);
                    inline_next = sat_inc(inline_reg);
                end
                LINE_CODE:    code_next    = sat_inc(code_reg);
                LINE_COMMENT: comment_next = sat_inc(comment_reg);
                default:      blank_next   = sat_inc(blank_reg);
            endcase
        end
    end

    // Hold the counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            total_reg   <= '0;
            blank_reg   <= '0;
            code_reg    <= '0;
            comment_reg <= '0;
            inline_reg  <= '0;
        end else begin
            total_reg   <= total_next;
            blank_reg   <= blank_next;
            code_reg    <= code_next;
            comment_reg <= comment_next;
            inline_reg  <= inline_next;
        end
    end

endmodule

// ===== rtl/c_source_line_classifier_core.sv =====
// Top level of the C source line classifier: input stage, scanner, counters, result stage.
//
//  channel | dir | tdata                 | tlast       | tuser
//  s_*     | in  | char_code             | end_of_line | -
//  m_*     | out | five 32-bit totals    | -           | line_class
//
// One item per cycle while no line end waits on an untaken result; a line end moves from
// the input stage to the result stage. The rate is set by the scanner state register loop.
// rst_n clears the scanner state, the counters and both valid flags at once.
// A line end waits in the input stage while an earlier result is still not taken;
// items without a line end keep flowing past a stalled result.
module c_source_line_classifier_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] char_code
    input  logic         s_tlast,   // end_of_line
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,   // [31:0] total_lines, [63:32] blank_lines,
                                    // [95:64] code_lines, [127:96] comment_lines,
                                    // [159:128] inline_lines
    output logic [1:0]   m_tuser    // [1:0] line_class
);
    import clc_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_char_reg;
    logic        in_eol_reg;
    scan_state_t scan_reg;
    scan_state_t scan_next;
    line_flags_t flags;
    line_class_t line_class;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [159:0] out_data_reg;
    logic [1:0]   out_class_reg;
    logic         fire;
    logic         s_accept;

    logic [COUNT_WIDTH-1:0] total_next;
    logic [COUNT_WIDTH-1:0] blank_next;
    logic [COUNT_WIDTH-1:0] code_next;
    logic [COUNT_WIDTH-1:0] comment_next;
    logic [COUNT_WIDTH-1:0] inline_next;

    // Advance the held item unless it ends a line and the result slot is full and not taken
    assign fire     = in_valid_reg && (!in_eol_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (fire && in_eol_reg) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    clc_char_unit u_char (
        .state       (scan_reg),
        .char_code   (in_char_reg),
        .end_of_line (in_eol_reg),
        .fire        (fire),
        .state_next  (scan_next),
        .flags       (flags)
    );

    clc_line_counters #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_counters (
        .clk          (clk),
        .rst_n        (rst_n),
        .flags        (flags),
        .line_class   (line_class),
        .total_next   (total_next),
        .blank_next   (blank_next),
        .code_next    (code_next),
        .comment_next (comment_next),
        .inline_next  (inline_next)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            scan_reg      <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire) begin
                scan_reg <= scan_next;
            end
        end
    end

    // Input and result payload
    always_ff @(posedge clk)
    begin
        if (s_accept) begin
            in_char_reg <= s_tdata;
            in_eol_reg  <= s_tlast;
        end
        if (fire && in_eol_reg) begin
            out_class_reg <= line_class;
            out_data_reg  <= {32'(inline_next), 32'(comment_next), 32'(code_next),
                              32'(blank_next), 32'(total_next)};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_class_reg;

`ifndef ASSERT_OFF
    // A stalled item stays in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !fire) |=> in_valid_reg)
        else $error("input stage lost a stalled item");

    // A line end leaves no lookahead, ignore flag or line flags behind
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_eol_reg) |=> (!scan_reg.held_valid && !scan_reg.rest_ignored &&
                                  !scan_reg.line_saw_code && !scan_reg.line_saw_comment))
        else $error("per-line state not cleared at line end");

    // While the rest of a line is ignored no byte is held
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg.rest_ignored |-> !scan_reg.held_valid)
        else $error("byte held while rest of line ignored");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the C source line classifier core.
`timescale 1ns / 1ps

module tb;

    import clc_pkg::*;

    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_MAX = 8'hFF;
    localparam int HOLD_CYCLES = 300;

    // Expected per-line report
    typedef struct {
        line_class_t cls;
        logic [31:0] total;
        logic [31:0] blank;
        logic [31:0] code;
        logic [31:0] comment;
        logic [31:0] mixed;
    } line_tally_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;   // [7:0] char_code
    logic         s_tlast = 1'b0;    // end_of_line
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;           // [31:0] total, [63:32] blank, [95:64] code,
                                     // [127:96] comment, [159:128] inline
    logic [1:0]   m_tuser;           // [1:0] line_class

    // Scanner copy kept by the bench
    logic        in_comment = 1'b0;
    logic        in_string = 1'b0;
    logic [7:0]  pend_char = 8'h00;
    logic        pend_valid = 1'b0;
    logic        skip_next = 1'b0;
    logic        drop_rest = 1'b0;
    logic        saw_code = 1'b0;
    logic        saw_comment = 1'b0;
    logic [31:0] n_total = '0;
    logic [31:0] n_blank = '0;
    logic [31:0] n_code = '0;
    logic [31:0] n_comment = '0;
    logic [31:0] n_mixed = '0;

    line_tally_t tally_q[$];
    logic [7:0]  line_bytes[$];
    int          errors = 0;
    int          src_idle_pct = 0;
    int          sink_idle_pct = 0;
    logic        hold_toggle = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;

    c_source_line_classifier_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    // Saturating line counter step
    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    // Apply one byte h to the scanner state, with lookahead n when has_next
    function automatic void classify_byte(input logic [7:0] h, input logic has_next,
                                          input logic [7:0] n);
        if (h == CHAR_SPACE || (h >= CHAR_TAB && h <= CHAR_CR))
            return;
        if (in_comment)
        begin
            saw_comment = 1'b1;
            if (h == CHAR_STAR && has_next && n == CHAR_SLASH)
            begin
                skip_next = 1'b1;
                in_comment = 1'b0;
            end
        end
        else if (in_string)
        begin
            if (h == CHAR_BACKSLASH)
            begin
                if (has_next)
                    skip_next = 1'b1;
            end
            else if (h == CHAR_QUOTE)
                in_string = 1'b0;
            saw_code = 1'b1;
        end
        else if (h == CHAR_SLASH && has_next && n == CHAR_STAR)
        begin
            in_comment = 1'b1;
            saw_comment = 1'b1;
            skip_next = 1'b1;
        end
        else if (h == CHAR_SLASH && has_next && n == CHAR_SLASH)
        begin
            saw_comment = 1'b1;
            drop_rest = 1'b1;
        end
        else
        begin
            if (h == CHAR_QUOTE)
                in_string = 1'b1;
            saw_code = 1'b1;
        end
    endfunction

    // Advance the scanner by one accepted item; queue the line report at a line end
    function automatic void scan_char(input logic [7:0] c, input logic eol);
        line_tally_t t;
        if (!drop_rest)
        begin
            if (skip_next)
                skip_next = 1'b0;
            else
            begin
                if (pend_valid)
                    classify_byte(pend_char, 1'b1, c);
                if (skip_next)
                begin
                    skip_next = 1'b0;
                    pend_valid = 1'b0;
                end
                else if (drop_rest)
                    pend_valid = 1'b0;
                else
                begin
                    pend_char = c;
                    pend_valid = 1'b1;
                end
            end
        end
        if (!eol)
            return;
        if (pend_valid && !drop_rest)
            classify_byte(pend_char, 1'b0, CHAR_NUL);
        n_total = bump(n_total);
        if (saw_code)
        begin
            n_code = bump(n_code);
            if (saw_comment)
            begin
                n_mixed = bump(n_mixed);
                t.cls = LINE_INLINE;
            end
            else
                t.cls = LINE_CODE;
        end
        else if (saw_comment)
        begin
            n_comment = bump(n_comment);
            t.cls = LINE_COMMENT;
        end
        else
        begin
            n_blank = bump(n_blank);
            t.cls = LINE_BLANK;
        end
        t.total = n_total;
        t.blank = n_blank;
        t.code = n_code;
        t.comment = n_comment;
        t.mixed = n_mixed;
        tally_q.push_back(t);
        pend_char = 8'h00;
        pend_valid = 1'b0;
        skip_next = 1'b0;
        drop_rest = 1'b0;
        saw_code = 1'b0;
        saw_comment = 1'b0;
    endfunction

    // Fill line_bytes with a random line built from C-like pieces
    function automatic void build_line();
        int n_tok;
        line_bytes.delete();
        n_tok = $urandom_range(10);
        for (int k = 0; k < n_tok; k++)
        begin
            case ($urandom_range(11))
                0, 1, 2, 3: line_bytes.push_back(8'h61 + 8'($urandom_range(25)));
                4: line_bytes.push_back($urandom_range(1) ? CHAR_SPACE
                                                          : 8'($urandom_range(13, 9)));
                5:
                begin
                    line_bytes.push_back(CHAR_SLASH);
                    line_bytes.push_back(CHAR_STAR);
                end
                6:
                begin
                    line_bytes.push_back(CHAR_STAR);
                    line_bytes.push_back(CHAR_SLASH);
                end
                7:
                begin
                    line_bytes.push_back(CHAR_SLASH);
                    line_bytes.push_back(CHAR_SLASH);
                end
                8: line_bytes.push_back(CHAR_QUOTE);
                9: line_bytes.push_back(CHAR_BACKSLASH);
                10: line_bytes.push_back($urandom_range(1) ? CHAR_SLASH : CHAR_STAR);
                default: line_bytes.push_back(8'($urandom_range(255)));
            endcase
        end
        if (line_bytes.size() == 0 || $urandom_range(9) < 7)
            line_bytes.push_back(CHAR_LF);
    endfunction

    // Report one mismatch and count it
    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %0d want %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Offer one item, with a random gap first, and hold it until accepted
    task automatic send_char(input logic [7:0] c, input logic eol);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= eol;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        scan_char(c, eol);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_built_line(inout int sent);
        build_line();
        foreach (line_bytes[i])
            send_char(line_bytes[i], i == line_bytes.size() - 1);
        sent += line_bytes.size();
    endtask

    // Stop offering and wait until every queued line report has come back
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (tally_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Receiver: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        line_tally_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (tally_q.size() == 0)
                flag_mismatch("result with nothing expected, total", m_tdata[31:0], '0);
            else
            begin
                want = tally_q.pop_front();
                if (m_tuser != want.cls)
                    flag_mismatch("line_class", 32'(m_tuser), 32'(want.cls));
                if (m_tdata[31:0] != want.total)
                    flag_mismatch("total_lines", m_tdata[31:0], want.total);
                if (m_tdata[63:32] != want.blank)
                    flag_mismatch("blank_lines", m_tdata[63:32], want.blank);
                if (m_tdata[95:64] != want.code)
                    flag_mismatch("code_lines", m_tdata[95:64], want.code);
                if (m_tdata[127:96] != want.comment)
                    flag_mismatch("comment_lines", m_tdata[127:96], want.comment);
                if (m_tdata[159:128] != want.mixed)
                    flag_mismatch("inline_lines", m_tdata[159:128], want.mixed);
            end
        end
    end

    // Hand-picked lines: byte extremes, every line class and the corner cases
    task automatic test_directed();
        src_idle_pct = 19;
        sink_idle_pct <= 65;
        send_text("\n");
        send_char(CHAR_NUL, 1'b0);
        send_char(CHAR_MAX, 1'b1);
        send_text("//");
        send_text("a/*b*/");
        // slash at a line end pairs with nothing on the next line
        send_text("x/");
        send_text("*y");
        // slash-star-slash opens a comment and leaves it open
        send_text("/*/");
        send_text("*/");
        // backslash at a line end inside a string escapes nothing
        send_text("\"\\");
        send_text("\"");
        // a blank between slash and star opens nothing
        send_text("/ *");
        wait_drain();
    endtask

    task automatic run_random_phase(input int n_items, input int src_pct, input int sink_pct);
        int sent;
        sent = 0;
        src_idle_pct = src_pct;
        sink_idle_pct <= sink_pct;
        while (sent < n_items)
        begin
            if ($urandom_range(9) == 0)
            begin
                // noise: any byte, line end now and then
                send_char(8'($urandom_range(255)), $urandom_range(3) == 0);
                sent++;
            end
            else
                send_built_line(sent);
        end
        wait_drain();
    endtask

    task automatic test_random();
        run_random_phase(330, 19, 65);
        run_random_phase(330, 65, 19);
        run_random_phase(340, 0, 0);
    endtask

    // Hold the receiver off while the sender keeps pushing short lines
    task automatic test_backpressure();
        int sent;
        sent = 0;
        src_idle_pct = 0;
        sink_idle_pct <= 0;
        hold_toggle <= ~hold_toggle;
        while (sent < 120)
            send_built_line(sent);
        wait_drain();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_backpressure();
        repeat (8) @(posedge clk);
        if (errors == 0 && tally_q.size() == 0)
            $display("c_source_line_classifier_core test passed");
        else
            $display("c_source_line_classifier_core test failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("c_source_line_classifier_core test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/clc_pkg.sv
rtl/clc_char_unit.sv
rtl/clc_line_counters.sv
rtl/c_source_line_classifier_core.sv
bench/tb.sv
